[hdl/beam_frame_vector_rotate_top_defines.svh]
// ----------------------------------------------------------------------------
// Beam frame rotation: assertion macros
// Concurrent checks used at the end of the top level. They are empty for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef BEAM_FRAME_VECTOR_ROTATE_TOP_DEFINES_SVH
`define BEAM_FRAME_VECTOR_ROTATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BFVR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfvr assertion failed");

// Next-cycle implication.
`define BFVR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfvr assertion failed");

`else

`define BFVR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define BFVR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[hdl/bfvr_pkg.sv]
// ----------------------------------------------------------------------------
// Beam frame rotation: shared package
// Widths, reset values and the side data carried through the long units.
// ----------------------------------------------------------------------------
package bfvr_pkg;

   // Threshold register reset value (Q0.16).
   localparam logic [15:0] THR_RESET = 16'hFFFF;

   // Unit geometry.
   localparam int SQRT_RAD_W = 62;   // radicand width
   localparam int SQRT_ROOT_W = 31;  // root width
   localparam int DIV_NUM_W = 61;    // numerator width
   localparam int DIV_DEN_W = 31;    // denominator width
   localparam int DIV_QUO_W = 31;    // quotient width

   // Q1.30 one.
   localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

   // Side data alongside the first square root.
   typedef struct packed {
      logic [2:0][29:0] mag;
      logic [2:0]       neg;
      logic [2:0][31:0] vec;
      logic             degen;
   } bfvr_side_a_type;

   // Side data alongside the cosine division.
   typedef struct packed {
      logic [2:0]       neg;
      logic [2:0][31:0] vec;
      logic             degen;
   } bfvr_side_b_type;

   // Side data alongside the horizontal length square root.
   typedef struct packed {
      logic [2:0][30:0] quo;
      logic [2:0]       neg;
      logic [2:0][31:0] vec;
      logic             degen;
   } bfvr_side_c_type;

   // Side data alongside the matrix entry division.
   typedef struct packed {
      logic [2:0][30:0] quo;
      logic [30:0]      lxy;
      logic [2:0]       neg;
      logic [2:0][31:0] vec;
      logic             degen;
   } bfvr_side_d_type;

   // Applies a sign to a 31-bit magnitude.
   function automatic logic signed [31:0] bfvr_apply_sign(input logic [30:0] mag,
                                                          input logic neg);
      logic signed [31:0] val;
      val = $signed({1'b0, mag});
      return neg ? -val : val;
   endfunction

endpackage

[hdl/bfvr_chan_if.sv]
// ----------------------------------------------------------------------------
// Beam frame rotation: channel interfaces
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bfvr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] start_z;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;
   logic signed [31:0] end_z;
   logic signed [31:0] in_x;
   logic signed [31:0] in_y;
   logic signed [31:0] in_z;

   modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                   in_x, in_y, in_z, input ready);
   modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                 in_x, in_y, in_z, output ready);
endinterface

interface bfvr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic               degenerate;

   modport source (output valid, out_x, out_y, out_z, degenerate, input ready);
   modport sink (input valid, out_x, out_y, out_z, degenerate, output ready);
endinterface

interface bfvr_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[hdl/bfvr_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// Beam frame rotation: pipelined integer square root
// Floor square root, one root bit per register stage, with side data and a
// common stall enable.
// ----------------------------------------------------------------------------
module bfvr_sqrt_pipe
   import bfvr_pkg::*;
#(
   parameter int NW = SQRT_RAD_W,
   parameter int RW = SQRT_ROOT_W,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_rad,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [RW-1:0] out_root,
   output logic [SW-1:0] out_side
);

   localparam int TW = NW + 2;

   logic          valid_ff [RW];
   logic [TW-1:0] rem_ff   [RW];
   logic [RW-1:0] root_ff  [RW];
   logic [SW-1:0] side_ff  [RW];

   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int K = RW - 1 - s;
      logic          valid_prev;
      logic [TW-1:0] rem_prev;
      logic [RW-1:0] root_prev;
      logic [SW-1:0] side_prev;
      logic [TW-1:0] trial;

      // Stage input comes from the port or from the stage before.
      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = TW'(in_rad);
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign rem_prev   = rem_ff[s-1];
         assign root_prev  = root_ff[s-1];
         assign side_prev  = side_ff[s-1];
      end

      // Growth of the square when this root bit is set.
      assign trial = (TW'(root_prev) << (K + 1)) + (TW'(1) << (2 * K));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[s] <= side_prev;
            if (rem_prev >= trial) begin
               rem_ff[s]  <= rem_prev - trial;
               root_ff[s] <= root_prev | (RW'(1) << K);
            end else begin
               rem_ff[s]  <= rem_prev;
               root_ff[s] <= root_prev;
            end
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

[hdl/bfvr_div_pipe.sv]
// ----------------------------------------------------------------------------
// Beam frame rotation: pipelined restoring divider
// Several numerators over one common denominator, one quotient bit per
// register stage. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module bfvr_div_pipe
   import bfvr_pkg::*;
#(
   parameter int LN = 1,
   parameter int NW = DIV_NUM_W,
   parameter int DW = DIV_DEN_W,
   parameter int QW = DIV_QUO_W,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num [LN],
   input  logic [DW-1:0] in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_quo [LN],
   output logic [SW-1:0] out_side
);

   localparam int TW = (DW + QW > NW) ? DW + QW : NW;

   logic          valid_ff [QW];
   logic [TW-1:0] rem_ff   [QW][LN];
   logic [QW-1:0] quo_ff   [QW][LN];
   logic [DW-1:0] den_ff   [QW];
   logic [SW-1:0] side_ff  [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int K = QW - 1 - s;
      logic          valid_prev;
      logic [TW-1:0] rem_prev [LN];
      logic [QW-1:0] quo_prev [LN];
      logic [DW-1:0] den_prev;
      logic [SW-1:0] side_prev;
      logic [TW-1:0] dsh;

      if (s == 0) begin : g_first
         assign valid_prev = in_valid;
         assign den_prev   = in_den;
         assign side_prev  = in_side;
         for (genvar l = 0; l < LN; l++) begin : g_lane
            assign rem_prev[l] = TW'(in_num[l]);
            assign quo_prev[l] = '0;
         end
      end else begin : g_next
         assign valid_prev = valid_ff[s-1];
         assign den_prev   = den_ff[s-1];
         assign side_prev  = side_ff[s-1];
         for (genvar l = 0; l < LN; l++) begin : g_lane
            assign rem_prev[l] = rem_ff[s-1][l];
            assign quo_prev[l] = quo_ff[s-1][l];
         end
      end

      // Denominator aligned to this quotient bit.
      assign dsh = TW'(den_prev) << K;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[s]  <= den_prev;
            side_ff[s] <= side_prev;
            for (int l = 0; l < LN; l++) begin
               if (rem_prev[l] >= dsh) begin
                  rem_ff[s][l] <= rem_prev[l] - dsh;
                  quo_ff[s][l] <= quo_prev[l] | (QW'(1) << K);
               end else begin
                  rem_ff[s][l] <= rem_prev[l];
                  quo_ff[s][l] <= quo_prev[l];
               end
            end
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_side  = side_ff[QW-1];
   for (genvar l = 0; l < LN; l++) begin : g_out
      assign out_quo[l] = quo_ff[QW-1][l];
   end

endmodule

[hdl/beam_frame_vector_rotate_top.sv]
// ----------------------------------------------------------------------------
// Beam frame rotation: top level
// Turns a beam's node pair into direction cosines and a local-frame matrix
// and rotates a Q16.16 vector by it, one request per cycle unless a response stalls.
//
//   Channel   Role     Contents
//   req_chan  sink     start/end node coordinates and the vector to rotate
//   rsp_chan  source   rotated vector and the degenerate flag
//   csr_chan  sink     vertical threshold (Q0.16), always ready
//
// One request enters per cycle while no response stalls; the two square
// roots and two divisions are each 31 stages at one bit per stage.
// Reset clears all valid bits and loads the threshold with its reset value.
// A stalled response holds the whole pipeline, so nothing is lost or
// repeated; requests are taken whenever the response register is empty or
// being read.
// ----------------------------------------------------------------------------
`include "beam_frame_vector_rotate_top_defines.svh"

module beam_frame_vector_rotate_top
   import bfvr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   bfvr_req_if.sink   req_chan,
   bfvr_rsp_if.source rsp_chan,
   bfvr_csr_if.sink   csr_chan
);

   logic pipe_en;
   logic rsp_valid_ff;

   // Threshold register.
   logic [15:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_chan.valid) begin
         thr_ff <= csr_chan.data;
      end
   end

   assign csr_chan.ready = 1'b1;

   // The whole pipeline moves unless a response waits.
   assign pipe_en        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = pipe_en;

   // Stage 1: node differences and their magnitudes.
   logic             s1_valid_ff;
   logic [32:0]      s1_mag_ff [3];
   logic [2:0]       s1_neg_ff;
   logic [2:0][31:0] s1_vec_ff;
   logic [32:0]      s1_dif_in [3];

   always_comb begin
      s1_dif_in[0] = {req_chan.end_x[31], req_chan.end_x}
                   - {req_chan.start_x[31], req_chan.start_x};
      s1_dif_in[1] = {req_chan.end_y[31], req_chan.end_y}
                   - {req_chan.start_y[31], req_chan.start_y};
      s1_dif_in[2] = {req_chan.end_z[31], req_chan.end_z}
                   - {req_chan.start_z[31], req_chan.start_z};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 3; i++) begin
            s1_neg_ff[i] <= s1_dif_in[i][32];
            s1_mag_ff[i] <= s1_dif_in[i][32] ? 33'd0 - s1_dif_in[i] : s1_dif_in[i];
         end
         s1_vec_ff <= {req_chan.in_z, req_chan.in_y, req_chan.in_x};
      end
   end

   // Stage 2: position of the top bit of the largest magnitude.
   logic             s2_valid_ff;
   logic [32:0]      s2_mag_ff [3];
   logic [2:0]       s2_neg_ff;
   logic [2:0][31:0] s2_vec_ff;
   logic [5:0]       s2_top_ff;
   logic             s2_degen_ff;
   logic [32:0]      s2_or_in;
   logic [5:0]       s2_top_in;

   always_comb begin
      s2_or_in  = s1_mag_ff[0] | s1_mag_ff[1] | s1_mag_ff[2];
      s2_top_in = '0;
      for (int b = 0; b < 33; b++) begin
         if (s2_or_in[b]) begin
            s2_top_in = 6'(b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_mag_ff   <= s1_mag_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_vec_ff   <= s1_vec_ff;
         s2_top_ff   <= s2_top_in;
         s2_degen_ff <= (s2_or_in == '0);
      end
   end

   // Stage 3: common scaling so that the largest magnitude tops out at bit 29.
   logic             s3_valid_ff;
   logic [2:0][29:0] s3_mag_ff;
   logic [2:0]       s3_neg_ff;
   logic [2:0][31:0] s3_vec_ff;
   logic             s3_degen_ff;
   logic [2:0][29:0] s3_mag_in;
   logic [5:0]       s3_sh_in;

   always_comb begin
      if (s2_top_ff > 6'd29) begin
         s3_sh_in = s2_top_ff - 6'd29;
         for (int i = 0; i < 3; i++) begin
            s3_mag_in[i] = 30'(s2_mag_ff[i] >> s3_sh_in);
         end
      end else begin
         s3_sh_in = 6'd29 - s2_top_ff;
         for (int i = 0; i < 3; i++) begin
            s3_mag_in[i] = 30'(s2_mag_ff[i] << s3_sh_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s3_mag_ff   <= s3_mag_in;
         s3_neg_ff   <= s2_neg_ff;
         s3_vec_ff   <= s2_vec_ff;
         s3_degen_ff <= s2_degen_ff;
      end
   end

   // Stage 4: squares of the scaled magnitudes.
   logic             s4_valid_ff;
   logic [59:0]      s4_sq_ff [3];
   bfvr_side_a_type  s4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 3; i++) begin
            s4_sq_ff[i] <= 60'(s3_mag_ff[i]) * 60'(s3_mag_ff[i]);
         end
         s4_side_ff.mag   <= s3_mag_ff;
         s4_side_ff.neg   <= s3_neg_ff;
         s4_side_ff.vec   <= s3_vec_ff;
         s4_side_ff.degen <= s3_degen_ff;
      end
   end

   // Stage 5: squared length.
   logic                  s5_valid_ff;
   logic [SQRT_RAD_W-1:0] s5_lsq_ff;
   bfvr_side_a_type       s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s5_lsq_ff  <= SQRT_RAD_W'(s4_sq_ff[0]) + SQRT_RAD_W'(s4_sq_ff[1])
                     + SQRT_RAD_W'(s4_sq_ff[2]);
         s5_side_ff <= s4_side_ff;
      end
   end

   // Beam length.
   logic                   len_valid;
   logic [SQRT_ROOT_W-1:0] len_root;
   bfvr_side_a_type        len_side;

   bfvr_sqrt_pipe #(
      .NW (SQRT_RAD_W),
      .RW (SQRT_ROOT_W),
      .SW ($bits(bfvr_side_a_type))
   ) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (s5_valid_ff),
      .in_rad    (s5_lsq_ff),
      .in_side   (s5_side_ff),
      .out_valid (len_valid),
      .out_root  (len_root),
      .out_side  (len_side)
   );

   // Direction cosine magnitudes.
   logic [DIV_NUM_W-1:0] cos_num [3];
   logic [DIV_DEN_W-1:0] cos_den;
   bfvr_side_b_type      cos_side_in;
   logic                 cos_valid;
   logic [DIV_QUO_W-1:0] cos_quo [3];
   bfvr_side_b_type      cos_side;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cos_num[i] = DIV_NUM_W'({len_side.mag[i], 30'd0});
      end
      cos_den           = DIV_DEN_W'(len_root);
      cos_side_in.neg   = len_side.neg;
      cos_side_in.vec   = len_side.vec;
      cos_side_in.degen = len_side.degen;
   end

   bfvr_div_pipe #(
      .LN (3),
      .NW (DIV_NUM_W),
      .DW (DIV_DEN_W),
      .QW (DIV_QUO_W),
      .SW ($bits(bfvr_side_b_type))
   ) u_cos_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (len_valid),
      .in_num    (cos_num),
      .in_den    (cos_den),
      .in_side   (cos_side_in),
      .out_valid (cos_valid),
      .out_quo   (cos_quo),
      .out_side  (cos_side)
   );

   // Stage 6: squares of the x and y cosines.
   logic             s6_valid_ff;
   logic [61:0]      s6_sq_ff [2];
   bfvr_side_c_type  s6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s6_valid_ff <= cos_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 2; i++) begin
            s6_sq_ff[i] <= 62'(cos_quo[i]) * 62'(cos_quo[i]);
         end
         for (int i = 0; i < 3; i++) begin
            s6_side_ff.quo[i] <= 31'(cos_quo[i]);
         end
         s6_side_ff.neg   <= cos_side.neg;
         s6_side_ff.vec   <= cos_side.vec;
         s6_side_ff.degen <= cos_side.degen;
      end
   end

   // Stage 7: squared horizontal length.
   logic                  s7_valid_ff;
   logic [SQRT_RAD_W-1:0] s7_hsq_ff;
   bfvr_side_c_type       s7_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s7_hsq_ff  <= SQRT_RAD_W'(s6_sq_ff[0]) + SQRT_RAD_W'(s6_sq_ff[1]);
         s7_side_ff <= s6_side_ff;
      end
   end

   // Horizontal length.
   logic                   hor_valid;
   logic [SQRT_ROOT_W-1:0] hor_root;
   bfvr_side_c_type        hor_side;

   bfvr_sqrt_pipe #(
      .NW (SQRT_RAD_W),
      .RW (SQRT_ROOT_W),
      .SW ($bits(bfvr_side_c_type))
   ) u_hor_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (s7_valid_ff),
      .in_rad    (s7_hsq_ff),
      .in_side   (s7_side_ff),
      .out_valid (hor_valid),
      .out_root  (hor_root),
      .out_side  (hor_side)
   );

   // Stage 8: numerators of the entries divided by the horizontal length.
   logic                 s8_valid_ff;
   logic [DIV_NUM_W-1:0] s8_num_ff [4];
   bfvr_side_d_type      s8_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s8_valid_ff <= hor_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s8_num_ff[0] <= DIV_NUM_W'({hor_side.quo[1], 30'd0});
         s8_num_ff[1] <= DIV_NUM_W'({hor_side.quo[0], 30'd0});
         s8_num_ff[2] <= DIV_NUM_W'(62'(hor_side.quo[0]) * 62'(hor_side.quo[2]));
         s8_num_ff[3] <= DIV_NUM_W'(62'(hor_side.quo[1]) * 62'(hor_side.quo[2]));
         s8_side_ff.quo   <= hor_side.quo;
         s8_side_ff.lxy   <= 31'(hor_root);
         s8_side_ff.neg   <= hor_side.neg;
         s8_side_ff.vec   <= hor_side.vec;
         s8_side_ff.degen <= hor_side.degen;
      end
   end

   // Matrix entry magnitudes.
   logic                 ent_valid;
   logic [DIV_QUO_W-1:0] ent_quo [4];
   bfvr_side_d_type      ent_side;

   bfvr_div_pipe #(
      .LN (4),
      .NW (DIV_NUM_W),
      .DW (DIV_DEN_W),
      .QW (DIV_QUO_W),
      .SW ($bits(bfvr_side_d_type))
   ) u_ent_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (s8_valid_ff),
      .in_num    (s8_num_ff),
      .in_den    (DIV_DEN_W'(s8_side_ff.lxy)),
      .in_side   (s8_side_ff),
      .out_valid (ent_valid),
      .out_quo   (ent_quo),
      .out_side  (ent_side)
   );

   // Stage 9: signed matrix, or one of the vertical matrices.
   logic               s9_valid_ff;
   logic signed [31:0] s9_mat_ff [9];
   logic [2:0][31:0]   s9_vec_ff;
   logic               s9_degen_ff;
   logic signed [31:0] s9_mat_in [9];
   logic [30:0]        s9_thr_in;
   logic               s9_lz_in;
   logic               s9_up_in;
   logic               s9_dn_in;

   always_comb begin
      s9_thr_in = {1'b0, thr_ff, 14'd0};
      s9_lz_in  = (ent_side.lxy == '0);
      s9_up_in  = !ent_side.neg[2] && (ent_side.quo[2] > s9_thr_in);
      s9_dn_in  = ent_side.neg[2] && (ent_side.quo[2] > s9_thr_in);
      for (int i = 0; i < 9; i++) begin
         s9_mat_in[i] = '0;
      end
      priority if (s9_up_in) begin
         s9_mat_in[2] = Q30_ONE;
         s9_mat_in[4] = Q30_ONE;
         s9_mat_in[6] = -Q30_ONE;
      end else if (s9_dn_in) begin
         s9_mat_in[2] = -Q30_ONE;
         s9_mat_in[4] = Q30_ONE;
         s9_mat_in[6] = Q30_ONE;
      end else begin
         for (int i = 0; i < 3; i++) begin
            s9_mat_in[i] = bfvr_apply_sign(ent_side.quo[i], ent_side.neg[i]);
         end
         if (!s9_lz_in) begin
            s9_mat_in[3] = bfvr_apply_sign(31'(ent_quo[0]), !ent_side.neg[1]);
            s9_mat_in[4] = bfvr_apply_sign(31'(ent_quo[1]), ent_side.neg[0]);
            s9_mat_in[6] = bfvr_apply_sign(31'(ent_quo[2]),
                                           !(ent_side.neg[0] ^ ent_side.neg[2]));
            s9_mat_in[7] = bfvr_apply_sign(31'(ent_quo[3]),
                                           !(ent_side.neg[1] ^ ent_side.neg[2]));
         end
         s9_mat_in[8] = $signed({1'b0, ent_side.lxy});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s9_valid_ff <= ent_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s9_mat_ff   <= s9_mat_in;
         s9_vec_ff   <= ent_side.vec;
         s9_degen_ff <= ent_side.degen;
      end
   end

   // Stage 10: the nine products.
   logic               s10_valid_ff;
   logic signed [63:0] s10_prod_ff [9];
   logic               s10_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s10_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 9; i++) begin
            s10_prod_ff[i] <= s9_mat_ff[i] * $signed(s9_vec_ff[i % 3]);
         end
         s10_degen_ff <= s9_degen_ff;
      end
   end

   // Stage 11: row sums.
   logic               s11_valid_ff;
   logic signed [65:0] s11_acc_ff [3];
   logic               s11_degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s11_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int r = 0; r < 3; r++) begin
            s11_acc_ff[r] <= 66'(s10_prod_ff[3*r]) + 66'(s10_prod_ff[3*r+1])
                           + 66'(s10_prod_ff[3*r+2]);
         end
         s11_degen_ff <= s10_degen_ff;
      end
   end

   // Stage 12: rounding, saturation and the response register.
   logic [31:0] rsp_out_ff [3];
   logic        rsp_degen_ff;
   logic [31:0] rsp_out_in [3];
   logic [65:0] fin_mag_in [3];
   logic [65:0] fin_sum_in [3];
   logic [35:0] fin_rnd_in [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         fin_mag_in[r] = s11_acc_ff[r][65] ? 66'(-s11_acc_ff[r]) : 66'(s11_acc_ff[r]);
         fin_sum_in[r] = fin_mag_in[r] + (66'(1) << 29);
         fin_rnd_in[r] = fin_sum_in[r][65:30];
         if (s11_degen_ff) begin
            rsp_out_in[r] = '0;
         end else if (s11_acc_ff[r][65]) begin
            rsp_out_in[r] = (fin_rnd_in[r] > 36'h0_8000_0000) ? 32'h8000_0000
                          : 32'(36'd0 - fin_rnd_in[r]);
         end else begin
            rsp_out_in[r] = (fin_rnd_in[r] > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF
                          : fin_rnd_in[r][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= s11_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_out_ff   <= rsp_out_in;
         rsp_degen_ff <= s11_degen_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_x      = $signed(rsp_out_ff[0]);
   assign rsp_chan.out_y      = $signed(rsp_out_ff[1]);
   assign rsp_chan.out_z      = $signed(rsp_out_ff[2]);
   assign rsp_chan.degenerate = rsp_degen_ff;

   // Checks.
   `BFVR_ASSERT_IMP(a_stall_blocks_req, clock, reset, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready)
   `BFVR_ASSERT_IMP(a_degen_zero, clock, reset, rsp_chan.valid && rsp_chan.degenerate, rsp_chan.out_x == 0 && rsp_chan.out_y == 0 && rsp_chan.out_z == 0)
   `BFVR_ASSERT_NEXT(a_csr_write, clock, reset, csr_chan.valid && csr_chan.ready, thr_ff == $past(csr_chan.data))

endmodule

[test/tb_beam_frame_vector_rotate_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Beam frame rotation: testbench
// Streams beams and vectors through the block under random gaps on both
// channels and a long hold-off on the response side. Each response is checked
// against its table entry or a cycle-free model of the direction-cosine
// rotation, over several vertical threshold settings including both extremes.
// ----------------------------------------------------------------------------
module tb_beam_frame_vector_rotate_top;
   import bfvr_pkg::*;

   typedef struct {
      logic signed [31:0] sx, sy, sz, ex, ey, ez, vx, vy, vz;
   } beam_req_type;

   typedef struct {
      logic signed [31:0] ox, oy, oz;
      logic               degen;
   } rotated_type;

   typedef struct {
      beam_req_type req;
      bit           known;
      rotated_type  rsp;
   } beam_row_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 150;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_PER_PHASE = 190;

   logic clock;
   logic reset;

   bfvr_req_if req_chan();
   bfvr_rsp_if rsp_chan();
   bfvr_csr_if csr_chan();

   beam_frame_vector_rotate_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   rotated_type rotated_q[$];
   logic [15:0] threshold;
   int          fail_count;
   int          request_count;
   int          response_count;
   int          vertical_count;
   int          degen_count;
   bit          hold_req;
   bit          no_idle;
   int          idle_cycles;

   // Clock generation.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Integer square root, rounded down.
   function automatic longint unsigned floor_sqrt(input longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Quotient truncated towards zero, zero for an empty denominator.
   function automatic longint trunc_div(input longint num, input longint den);
      if (den <= 0) return 0;
      return num / den;
   endfunction

   // Rounds a Q17.46-style sum back to Q16.16 and saturates it.
   function automatic logic signed [31:0] round_sat(input longint acc);
      longint unsigned mag;
      longint unsigned r;
      mag = acc < 0 ? -acc : acc;
      r = (mag + (64'd1 << 29)) >> 30;
      if (acc < 0) return r > 64'h8000_0000 ? 32'sh8000_0000 : -longint'(r);
      return r > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : longint'(r);
   endfunction

   // Rotates the vector into the local frame of the beam.
   function automatic rotated_type rotate_into_beam(input beam_req_type b,
                                                    input logic [15:0] thr);
      rotated_type     res;
      longint          d[3], c[3], v[3], r[9], acc[3], q, thr_q30;
      longint unsigned m[3], mx, len, lxy;
      int              p;
      d[0] = longint'(b.ex) - longint'(b.sx);
      d[1] = longint'(b.ey) - longint'(b.sy);
      d[2] = longint'(b.ez) - longint'(b.sz);
      v[0] = b.vx;
      v[1] = b.vy;
      v[2] = b.vz;
      for (int i = 0; i < 3; i++) m[i] = d[i] < 0 ? -d[i] : d[i];
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      if (mx == 0) begin
         res.ox = 0;
         res.oy = 0;
         res.oz = 0;
         res.degen = 1'b1;
         return res;
      end
      p = 0;
      while (p < 63 && (mx >> (p + 1)) != 0) p++;
      for (int i = 0; i < 3; i++) m[i] = p > 29 ? m[i] >> (p - 29) : m[i] << (29 - p);
      len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
         q = longint'((m[i] << 30) / len);
         c[i] = d[i] < 0 ? -q : q;
      end
      lxy = floor_sqrt(c[0] * c[0] + c[1] * c[1]);
      r[0] = c[0];
      r[1] = c[1];
      r[2] = c[2];
      r[3] = -trunc_div(c[1] * Q30_ONE, lxy);
      r[4] = trunc_div(c[0] * Q30_ONE, lxy);
      r[5] = 0;
      r[6] = -trunc_div(c[0] * c[2], lxy);
      r[7] = -trunc_div(c[1] * c[2], lxy);
      r[8] = lxy;
      thr_q30 = longint'(thr) << 14;
      // Beams along global z take the fixed vertical frames.
      if (c[2] > thr_q30) begin
         for (int i = 0; i < 9; i++) r[i] = 0;
         r[2] = Q30_ONE;
         r[4] = Q30_ONE;
         r[6] = -Q30_ONE;
      end
      if (c[2] < -thr_q30) begin
         for (int i = 0; i < 9; i++) r[i] = 0;
         r[2] = -Q30_ONE;
         r[4] = Q30_ONE;
         r[6] = Q30_ONE;
      end
      for (int i = 0; i < 3; i++) begin
         acc[i] = r[3*i] * v[0] + r[3*i+1] * v[1] + r[3*i+2] * v[2];
      end
      res.ox = round_sat(acc[0]);
      res.oy = round_sat(acc[1]);
      res.oz = round_sat(acc[2]);
      res.degen = 1'b0;
      return res;
   endfunction

   function automatic beam_row_type row(input logic signed [31:0] sx, sy, sz, ex, ey, ez,
                                        vx, vy, vz, input bit known,
                                        input logic signed [31:0] ox, oy, oz,
                                        input logic degen);
      beam_row_type t;
      t.req = '{sx, sy, sz, ex, ey, ez, vx, vy, vz};
      t.known = known;
      t.rsp = '{ox, oy, oz, degen};
      return t;
   endfunction

   // Sends one request after a random gap; the expectation is queued at acceptance.
   task automatic send_beam(input beam_req_type b, input bit known, input rotated_type typed);
      int          gap;
      rotated_type want;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.start_x <= b.sx;
      req_chan.start_y <= b.sy;
      req_chan.start_z <= b.sz;
      req_chan.end_x   <= b.ex;
      req_chan.end_y   <= b.ey;
      req_chan.end_z   <= b.ez;
      req_chan.in_x    <= b.vx;
      req_chan.in_y    <= b.vy;
      req_chan.in_z    <= b.vz;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      want = known ? typed : rotate_into_beam(b, threshold);
      rotated_q.push_back(want);
      request_count++;
      if (want.degen) degen_count++;
   endtask

   // Writes the threshold once the pipeline has drained.
   task automatic write_threshold(input logic [15:0] value);
      req_chan.valid <= 1'b0;
      wait (rotated_q.size() == 0);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      csr_chan.valid <= 1'b0;
      threshold = value;
   endtask

   function automatic logic signed [31:0] rand_coord(input int span);
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 2 * span)) - span;
         2: return 0;
         default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      endcase
   endfunction

   // Random beam: mostly ordinary, with axis-aligned, near-vertical and zero-length ones.
   function automatic beam_req_type rand_beam();
      beam_req_type b;
      int           kind;
      b.sx = rand_coord(1 << 20);
      b.sy = rand_coord(1 << 20);
      b.sz = rand_coord(1 << 20);
      b.vx = $urandom_range(0, 3) == 0 ? rand_coord(1 << 18) : $urandom;
      b.vy = $urandom_range(0, 3) == 0 ? rand_coord(1 << 18) : $urandom;
      b.vz = $urandom_range(0, 3) == 0 ? rand_coord(1 << 18) : $urandom;
      kind = $urandom_range(0, 9);
      case (kind)
         0: begin
            b.ex = b.sx;
            b.ey = b.sy;
            b.ez = b.sz;
         end
         1: begin
            b.ex = b.sx + $signed($urandom_range(0, 4)) - 2;
            b.ey = b.sy + $signed($urandom_range(0, 4)) - 2;
            b.ez = b.sz + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1) * $urandom_range(1, 1 << 24);
         end
         2: begin
            b.ex = b.sx + ($urandom_range(0, 1) ? $urandom_range(0, 1 << 16) : 0);
            b.ey = b.sy;
            b.ez = b.sz + $signed($urandom_range(0, 1 << 17)) - (1 << 16);
         end
         3, 4: begin
            b.ex = $urandom;
            b.ey = $urandom;
            b.ez = $urandom;
         end
         default: begin
            b.ex = b.sx + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            b.ey = b.sy + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            b.ez = b.sz + $signed($urandom_range(0, 1 << 22)) - (1 << 21);
         end
      endcase
      return b;
   endfunction

   // Response side: random back-pressure, with one long hold-off on request.
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         int wait_n;
         wait_n = no_idle ? 0 : $urandom_range(0, 8);
         if (hold_req) begin
            hold_req = 1'b0;
            wait_n = HOLD_CYCLES;
         end
         if (wait_n > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (wait_n) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready)) @(posedge clock);
      end
   end

   // Response checker.
   always @(posedge clock) begin
      rotated_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         response_count++;
         if (rotated_q.size() == 0) begin
            $error("response with nothing expected");
            fail_count++;
         end else begin
            want = rotated_q.pop_front();
            if (rsp_chan.out_x !== want.ox) begin
               $error("out_x expected %0d actual %0d", want.ox, rsp_chan.out_x);
               fail_count++;
            end
            if (rsp_chan.out_y !== want.oy) begin
               $error("out_y expected %0d actual %0d", want.oy, rsp_chan.out_y);
               fail_count++;
            end
            if (rsp_chan.out_z !== want.oz) begin
               $error("out_z expected %0d actual %0d", want.oz, rsp_chan.out_z);
               fail_count++;
            end
            if (rsp_chan.degenerate !== want.degen) begin
               $error("degenerate expected %0d actual %0d", want.degen,
                      rsp_chan.degenerate);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", rotated_q.size());
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Main stimulus.
   initial begin
      beam_row_type rows[$];
      rotated_type  none;
      logic [15:0]  phases[6];
      int           base;
      fail_count = 0;
      request_count = 0;
      response_count = 0;
      degen_count = 0;
      idle_cycles = 0;
      hold_req = 1'b0;
      no_idle = 1'b0;
      threshold = THR_RESET;
      none = '{0, 0, 0, 1'b0};
      reset = 1'b1;
      req_chan.valid = 1'b0;
      {req_chan.start_x, req_chan.start_y, req_chan.start_z} = '0;
      {req_chan.end_x, req_chan.end_y, req_chan.end_z} = '0;
      {req_chan.in_x, req_chan.in_y, req_chan.in_z} = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table at the reset threshold.
      base = 1 << 16;
      rows.push_back(row(0, 0, 0, 0, 0, 0, 1, 2, 3, 1, 0, 0, 0, 1));
      rows.push_back(row(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                         32'sh8000_0000, 1, 0, 0, 0, 1));
      rows.push_back(row(0, 0, 0, 0, 0, base, 1, 2, 3, 1, 3, 2, -1, 0));
      rows.push_back(row(0, 0, 0, 0, 0, base, 32'sh8000_0000, 5, 7, 1, 7, 5,
                         32'sh7FFF_FFFF, 0));
      rows.push_back(row(0, 0, base, 0, 0, 0, 1, 2, 3, 1, -3, 2, 1, 0));
      rows.push_back(row(0, 0, 0, base, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 5, 1,
                         32'sh7FFF_FFFF, 32'sh8000_0000, 5, 0));
      rows.push_back(row(base, 0, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 7, 1,
                         32'sh7FFF_FFFF, 32'sh8000_0001, 7, 0));
      rows.push_back(row(0, 0, 0, 0, base, 0, 4, 9, 6, 1, 9, -4, 6, 0));
      rows.push_back(row(32'sh8000_0000, 0, 0, 32'sh7FFF_FFFF, 0, 0, 1, 1, 1, 1,
                         1, 1, 1, 0));
      rows.push_back(row(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 0, 0, 0, 0, 0));
      rows.push_back(row(32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                         32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                         0, 0, 0, 0, 0));
      rows.push_back(row(0, 0, 0, base, base, base, base, 2 * base, 3 * base, 0, 0, 0, 0, 0));
      rows.push_back(row(32'sh7FFF_FFFE, 5, -9, 32'sh7FFF_FFFF, 5, -9, 100, -100, 1, 0,
                         0, 0, 0, 0));
      rows.push_back(row(3, 7, 0, 3, 8, 1, 12345, -54321, 999, 0, 0, 0, 0, 0));
      rows.push_back(row(-base, 2 * base, 3, 5 * base, -base, 7 * base, 0, 0, 0, 0,
                         0, 0, 0, 0));
      rows.push_back(row(0, 0, 0, 1, 0, 1 << 30, -77, 88, -99, 0, 0, 0, 0, 0));
      foreach (rows[i]) send_beam(rows[i].req, rows[i].known, rows[i].known ? rows[i].rsp : none);

      // Random phases over several threshold settings.
      phases = '{16'hFFFF, 16'h0000, 16'd46341, 16'h0001, 16'hFFFF, 16'h8000};
      phases[5] = $urandom_range(0, 65535);
      foreach (phases[ph]) begin
         write_threshold(phases[ph]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            no_idle = (n >= 60 && n < 100);
            if (ph == 1 && n == 110) hold_req = 1'b1;
            send_beam(rand_beam(), 0, none);
         end
         no_idle = 1'b0;
      end
      req_chan.valid <= 1'b0;

      wait (rotated_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d requests (%0d zero-length) over %0d threshold settings; %0d responses",
               request_count, degen_count, 7, response_count);
      if (fail_count == 0 && rotated_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
